[sv/psp_pkg.sv]
// ----------------------------------------------------------------------------
// psp_pkg: shared types, constants and helpers for the particle step pipeline
// Field widths, register codes, reset values and saturation helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package psp_pkg;

    localparam int DATA_W        = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int DT_W          = 17;
    localparam int GAIN_W        = 17;
    localparam int GRAV_W        = 26;
    localparam int DRAG_W        = 20;
    localparam int PROD_W        = 50;
    localparam int DEN_W         = 32;
    localparam int NUM_W         = 64;
    localparam int QUO_W         = 32;
    localparam int DIV_BPS       = 4;
    localparam int DIV_STAGES    = QUO_W / DIV_BPS;
    localparam int LANES         = 3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOUNCE_GAIN  = 2'd2;

    localparam logic [DT_W-1:0]          STEP_TIME_RST    = 17'd1092;
    localparam logic signed [DATA_W-1:0] FLOOR_HEIGHT_RST = 32'sd32768;
    localparam logic [GAIN_W-1:0]        BOUNCE_GAIN_RST  = 17'd19661;

    localparam logic signed [63:0] S32_MAX_W = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN_W = -64'sd2147483648;

    typedef struct packed {
        logic signed [DATA_W-1:0] px;
        logic signed [DATA_W-1:0] py;
        logic signed [DATA_W-1:0] pz;
        logic signed [DATA_W-1:0] vx;
        logic signed [DATA_W-1:0] vy;
        logic signed [DATA_W-1:0] vz;
        logic signed [DATA_W-1:0] life;
        logic signed [DATA_W-1:0] rot;
        logic signed [DATA_W-1:0] spin;
        logic [GRAV_W-1:0]        grav;
        logic [DRAG_W-1:0]        drag;
        logic                     decal;
    } item_t;

    typedef struct packed {
        logic [DT_W-1:0]          dt;
        logic signed [DATA_W-1:0] floor_h;
        logic [GAIN_W-1:0]        gain;
    } cfg_t;

    // Side data that rides along the divider and the back end
    typedef struct packed {
        logic signed [DATA_W-1:0] px;
        logic signed [DATA_W-1:0] py;
        logic signed [DATA_W-1:0] pz;
        logic signed [DATA_W-1:0] vx;
        logic signed [DATA_W-1:0] vy;
        logic signed [DATA_W-1:0] vz;
        logic signed [DATA_W-1:0] life;
        logic signed [DATA_W-1:0] rot;
        logic                     alive;
        logic                     decal;
        logic [DEN_W-1:0]         den;
        logic [LANES-1:0]         neg;
    } side_t;

    function automatic logic signed [63:0] sx64(input logic signed [DATA_W-1:0] v);
        return $signed({{32{v[DATA_W-1]}}, v});
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
        if (v > S32_MAX_W)
            return 32'sh7fffffff;
        else if (v < S32_MIN_W)
            return 32'sh80000000;
        else
            return v[DATA_W-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] mag32(input logic signed [DATA_W-1:0] v);
        logic [DATA_W-1:0] u;
        u = v;
        return v[DATA_W-1] ? (~u + 32'd1) : u;
    endfunction

endpackage

`default_nettype wire

[sv/psp_front.sv]
// ----------------------------------------------------------------------------
// psp_front: life, gravity, drag denominator, spin and divider numerators
// Three register stages ahead of the drag divider.
// ----------------------------------------------------------------------------
`default_nettype none

module psp_front #(
    parameter int FRAC_BITS = psp_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     adv,
    input  wire logic                                     in_vld,
    input  wire psp_pkg::item_t                           item,
    input  wire psp_pkg::cfg_t                            cfg,
    output logic                                          out_vld,
    output logic [psp_pkg::LANES-1:0][psp_pkg::NUM_W-1:0] num,
    output psp_pkg::side_t                                side
);

    localparam logic [psp_pkg::PROD_W-1:0] HALF = psp_pkg::PROD_W'(1) << (FRAC_BITS - 1);
    localparam logic [psp_pkg::DEN_W-1:0]  ONE  = psp_pkg::DEN_W'(1) << FRAC_BITS;

    // Stage A: products and life
    logic                                a_vld_reg;
    psp_pkg::item_t                      a_item_reg;
    logic signed [psp_pkg::DATA_W-1:0]   a_life_reg, a_life_next;
    logic                                a_alive_reg, a_alive_next;
    logic [psp_pkg::PROD_W-1:0]          a_gp_reg, a_gp_next;
    logic [psp_pkg::PROD_W-1:0]          a_dp_reg, a_dp_next;
    logic [psp_pkg::PROD_W-1:0]          a_sp_reg, a_sp_next;

    always_comb
    begin
        a_life_next  = psp_pkg::sat32(psp_pkg::sx64(item.life) - $signed(64'(cfg.dt)));
        a_alive_next = !a_life_next[psp_pkg::DATA_W-1] && (a_life_next != '0);
        a_gp_next    = item.grav * cfg.dt;
        a_dp_next    = item.drag * cfg.dt;
        a_sp_next    = psp_pkg::mag32(item.spin) * cfg.dt;
    end

    // Stage B: gravity, denominator, rotation
    logic                                b_vld_reg;
    psp_pkg::item_t                      b_item_reg;
    logic signed [psp_pkg::DATA_W-1:0]   b_life_reg;
    logic                                b_alive_reg;
    logic signed [psp_pkg::DATA_W-1:0]   b_vy_reg, b_vy_next;
    logic [psp_pkg::DEN_W-1:0]           b_den_reg, b_den_next;
    logic signed [psp_pkg::DATA_W-1:0]   b_rot_reg, b_rot_next;

    always_comb
    begin
        logic [psp_pkg::PROD_W-1:0] gr;
        logic [psp_pkg::PROD_W-1:0] dr;
        logic [psp_pkg::PROD_W-1:0] sr;
        logic signed [63:0]         sinc;
        gr = (a_gp_reg + HALF) >> FRAC_BITS;
        dr = (a_dp_reg + HALF) >> FRAC_BITS;
        sr = (a_sp_reg + HALF) >> FRAC_BITS;
        sinc = a_item_reg.spin[psp_pkg::DATA_W-1] ? -$signed(64'(sr)) : $signed(64'(sr));
        b_vy_next  = psp_pkg::sat32(psp_pkg::sx64(a_item_reg.vy) - $signed(64'(gr)));
        b_den_next = ONE + psp_pkg::DEN_W'(dr);
        // hold the old angle for a dead particle
        b_rot_next = a_alive_reg ? psp_pkg::sat32(psp_pkg::sx64(a_item_reg.rot) + sinc)
                                 : a_item_reg.rot;
    end

    // Stage C: magnitudes and numerators
    logic                                                c_vld_reg;
    logic [psp_pkg::LANES-1:0][psp_pkg::NUM_W-1:0]       c_num_reg, c_num_next;
    psp_pkg::side_t                                      c_side_reg, c_side_next;

    always_comb
    begin
        logic signed [psp_pkg::DATA_W-1:0] v [psp_pkg::LANES];
        v[0] = b_item_reg.vx;
        v[1] = b_vy_reg;
        v[2] = b_item_reg.vz;
        c_side_next.px    = b_item_reg.px;
        c_side_next.py    = b_item_reg.py;
        c_side_next.pz    = b_item_reg.pz;
        c_side_next.vx    = b_item_reg.vx;
        c_side_next.vy    = b_item_reg.vy;
        c_side_next.vz    = b_item_reg.vz;
        c_side_next.life  = b_life_reg;
        c_side_next.rot   = b_rot_reg;
        c_side_next.alive = b_alive_reg;
        c_side_next.decal = b_item_reg.decal;
        c_side_next.den   = b_den_reg;
        for (int i = 0; i < psp_pkg::LANES; i++)
        begin
            c_side_next.neg[i] = v[i][psp_pkg::DATA_W-1];
            c_num_next[i] = (psp_pkg::NUM_W'(psp_pkg::mag32(v[i])) << FRAC_BITS)
                          + psp_pkg::NUM_W'(b_den_reg >> 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_vld_reg <= in_vld;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_item_reg  <= item;
            a_life_reg  <= a_life_next;
            a_alive_reg <= a_alive_next;
            a_gp_reg    <= a_gp_next;
            a_dp_reg    <= a_dp_next;
            a_sp_reg    <= a_sp_next;
            b_item_reg  <= a_item_reg;
            b_life_reg  <= a_life_reg;
            b_alive_reg <= a_alive_reg;
            b_vy_reg    <= b_vy_next;
            b_den_reg   <= b_den_next;
            b_rot_reg   <= b_rot_next;
            c_num_reg   <= c_num_next;
            c_side_reg  <= c_side_next;
        end
    end

    assign out_vld = c_vld_reg;
    assign num     = c_num_reg;
    assign side    = c_side_reg;

endmodule

`default_nettype wire

[sv/psp_div.sv]
// ----------------------------------------------------------------------------
// psp_div: pipelined restoring divider, three lanes sharing one divisor
// A fixed number of quotient bits is settled in each stage.
// ----------------------------------------------------------------------------
`default_nettype none

module psp_div (
    input  wire logic                                           clk,
    input  wire logic                                           rst_n,
    input  wire logic                                           adv,
    input  wire logic                                           in_vld,
    input  wire logic [psp_pkg::LANES-1:0][psp_pkg::NUM_W-1:0]  num,
    input  wire psp_pkg::side_t                                 side_in,
    output logic                                                out_vld,
    output logic [psp_pkg::LANES-1:0][psp_pkg::QUO_W-1:0]       quo,
    output psp_pkg::side_t                                      side_out
);

    localparam int NS = psp_pkg::DIV_STAGES;

    logic [NS-1:0]                                        vld_reg;
    logic [psp_pkg::LANES-1:0][psp_pkg::DEN_W-1:0]        rem_reg  [NS];
    logic [psp_pkg::LANES-1:0][psp_pkg::QUO_W-1:0]        lq_reg   [NS];
    psp_pkg::side_t                                       side_reg [NS];

    for (genvar s = 0; s < NS; s++)
    begin : g_stage
        logic                                             vld_in;
        logic [psp_pkg::LANES-1:0][psp_pkg::DEN_W-1:0]    rem_in, rem_next;
        logic [psp_pkg::LANES-1:0][psp_pkg::QUO_W-1:0]    lq_in, lq_next;
        psp_pkg::side_t                                   sd_in;

        if (s == 0)
        begin : g_head
            assign vld_in = in_vld;
            assign sd_in  = side_in;
            for (genvar l = 0; l < psp_pkg::LANES; l++)
            begin : g_lane
                // the upper half is already below the divisor: quotient fits
                assign rem_in[l] = num[l][psp_pkg::NUM_W-1 -: psp_pkg::DEN_W];
                assign lq_in[l]  = num[l][psp_pkg::QUO_W-1:0];
            end
        end
        else
        begin : g_body
            assign vld_in = vld_reg[s-1];
            assign sd_in  = side_reg[s-1];
            assign rem_in = rem_reg[s-1];
            assign lq_in  = lq_reg[s-1];
        end

        always_comb
        begin
            logic [psp_pkg::DEN_W:0]   t;
            logic [psp_pkg::DEN_W-1:0] r;
            logic [psp_pkg::QUO_W-1:0] q;
            for (int l = 0; l < psp_pkg::LANES; l++)
            begin
                r = rem_in[l];
                q = lq_in[l];
                for (int k = 0; k < psp_pkg::DIV_BPS; k++)
                begin
                    t = {r, q[psp_pkg::QUO_W-1]};
                    q = q << 1;
                    if (t >= {1'b0, sd_in.den})
                    begin
                        r    = psp_pkg::DEN_W'(t - {1'b0, sd_in.den});
                        q[0] = 1'b1;
                    end
                    else
                    begin
                        r = t[psp_pkg::DEN_W-1:0];
                    end
                end
                rem_next[l] = r;
                lq_next[l]  = q;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else if (adv)
                vld_reg[s] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[s]  <= rem_next;
                lq_reg[s]   <= lq_next;
                side_reg[s] <= sd_in;
            end
        end
    end

    assign out_vld  = vld_reg[NS-1];
    assign quo      = lq_reg[NS-1];
    assign side_out = side_reg[NS-1];

endmodule

`default_nettype wire

[sv/psp_back.sv]
// ----------------------------------------------------------------------------
// psp_back: velocity sign and clamp, position advance, floor bounce
// Four register stages; the last one is the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module psp_back #(
    parameter int FRAC_BITS = psp_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire logic                                       adv,
    input  wire logic                                       in_vld,
    input  wire logic [psp_pkg::LANES-1:0][psp_pkg::QUO_W-1:0] quo,
    input  wire psp_pkg::side_t                             side,
    input  wire psp_pkg::cfg_t                              cfg,
    output logic                                            out_vld,
    output logic                                            alive,
    output logic signed [psp_pkg::DATA_W-1:0]               px,
    output logic signed [psp_pkg::DATA_W-1:0]               py,
    output logic signed [psp_pkg::DATA_W-1:0]               pz,
    output logic signed [psp_pkg::DATA_W-1:0]               vx,
    output logic signed [psp_pkg::DATA_W-1:0]               vy,
    output logic signed [psp_pkg::DATA_W-1:0]               vz,
    output logic signed [psp_pkg::DATA_W-1:0]               life,
    output logic signed [psp_pkg::DATA_W-1:0]               rot
);

    localparam logic [psp_pkg::PROD_W-1:0] HALF = psp_pkg::PROD_W'(1) << (FRAC_BITS - 1);

    // Stage D: signed, clamped velocities
    logic                                                  d_vld_reg;
    logic [psp_pkg::LANES-1:0][psp_pkg::DATA_W-1:0]        d_vel_reg, d_vel_next;
    psp_pkg::side_t                                        d_side_reg, d_side_next;

    always_comb
    begin
        logic signed [63:0] qs;
        d_side_next = side;
        for (int i = 0; i < psp_pkg::LANES; i++)
        begin
            qs = $signed(64'(quo[i]));
            d_vel_next[i] = psp_pkg::sat32(side.neg[i] ? -qs : qs);
        end
        // a dead particle keeps its old velocity
        if (side.alive)
        begin
            d_side_next.vx = d_vel_next[0];
            d_side_next.vy = d_vel_next[1];
            d_side_next.vz = d_vel_next[2];
        end
    end

    // Stage E: displacement and bounce products
    logic                                                  e_vld_reg;
    logic [psp_pkg::LANES-1:0][psp_pkg::PROD_W-1:0]        e_pm_reg, e_pm_next;
    logic [psp_pkg::LANES-1:0]                             e_neg_reg;
    logic [psp_pkg::PROD_W-1:0]                            e_bm_reg, e_bm_next;
    psp_pkg::side_t                                        e_side_reg;

    always_comb
    begin
        for (int i = 0; i < psp_pkg::LANES; i++)
            e_pm_next[i] = psp_pkg::mag32(d_vel_reg[i]) * cfg.dt;
        e_bm_next = psp_pkg::mag32(d_vel_reg[1]) * cfg.gain;
    end

    // Stage F: new positions and bounce speed
    logic                                                  f_vld_reg;
    logic [psp_pkg::LANES-1:0][psp_pkg::DATA_W-1:0]        f_pos_reg, f_pos_next;
    logic signed [psp_pkg::DATA_W-1:0]                     f_bvel_reg, f_bvel_next;
    psp_pkg::side_t                                        f_side_reg;

    always_comb
    begin
        logic signed [psp_pkg::DATA_W-1:0] p [psp_pkg::LANES];
        logic [psp_pkg::PROD_W-1:0]        r;
        logic signed [63:0]                inc;
        p[0] = e_side_reg.px;
        p[1] = e_side_reg.py;
        p[2] = e_side_reg.pz;
        for (int i = 0; i < psp_pkg::LANES; i++)
        begin
            r   = (e_pm_reg[i] + HALF) >> FRAC_BITS;
            inc = e_neg_reg[i] ? -$signed(64'(r)) : $signed(64'(r));
            f_pos_next[i] = psp_pkg::sat32(psp_pkg::sx64(p[i]) + inc);
        end
        r = (e_bm_reg + HALF) >> FRAC_BITS;
        f_bvel_next = psp_pkg::sat32($signed(64'(r)));
    end

    // Stage G: floor test and final select
    logic                                  g_vld_reg;
    logic                                  g_alive_reg;
    logic signed [psp_pkg::DATA_W-1:0]     g_px_reg, g_px_next;
    logic signed [psp_pkg::DATA_W-1:0]     g_py_reg, g_py_next;
    logic signed [psp_pkg::DATA_W-1:0]     g_pz_reg, g_pz_next;
    logic signed [psp_pkg::DATA_W-1:0]     g_vx_reg;
    logic signed [psp_pkg::DATA_W-1:0]     g_vy_reg, g_vy_next;
    logic signed [psp_pkg::DATA_W-1:0]     g_vz_reg;
    logic signed [psp_pkg::DATA_W-1:0]     g_life_reg;
    logic signed [psp_pkg::DATA_W-1:0]     g_rot_reg;

    always_comb
    begin
        logic signed [psp_pkg::DATA_W-1:0] ny;
        logic                              below;
        ny    = f_pos_reg[1];
        below = f_side_reg.alive && !f_side_reg.decal && (ny < cfg.floor_h);
        g_px_next = f_side_reg.alive ? f_pos_reg[0] : f_side_reg.px;
        g_pz_next = f_side_reg.alive ? f_pos_reg[2] : f_side_reg.pz;
        if (below)
        begin
            g_py_next = cfg.floor_h;
            g_vy_next = f_bvel_reg;
        end
        else
        begin
            g_py_next = f_side_reg.alive ? ny : f_side_reg.py;
            g_vy_next = f_side_reg.vy;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
            f_vld_reg <= 1'b0;
            g_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            d_vld_reg <= in_vld;
            e_vld_reg <= d_vld_reg;
            f_vld_reg <= e_vld_reg;
            g_vld_reg <= f_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_vel_reg   <= d_vel_next;
            d_side_reg  <= d_side_next;
            e_pm_reg    <= e_pm_next;
            for (int i = 0; i < psp_pkg::LANES; i++)
                e_neg_reg[i] <= d_vel_reg[i][psp_pkg::DATA_W-1];
            e_bm_reg    <= e_bm_next;
            e_side_reg  <= d_side_reg;
            f_pos_reg   <= f_pos_next;
            f_bvel_reg  <= f_bvel_next;
            f_side_reg  <= e_side_reg;
            g_alive_reg <= f_side_reg.alive;
            g_px_reg    <= g_px_next;
            g_py_reg    <= g_py_next;
            g_pz_reg    <= g_pz_next;
            g_vx_reg    <= f_side_reg.vx;
            g_vy_reg    <= g_vy_next;
            g_vz_reg    <= f_side_reg.vz;
            g_life_reg  <= f_side_reg.life;
            g_rot_reg   <= f_side_reg.rot;
        end
    end

    assign out_vld = g_vld_reg;
    assign alive   = g_alive_reg;
    assign px      = g_px_reg;
    assign py      = g_py_reg;
    assign pz      = g_pz_reg;
    assign vx      = g_vx_reg;
    assign vy      = g_vy_reg;
    assign vz      = g_vz_reg;
    assign life    = g_life_reg;
    assign rot     = g_rot_reg;

endmodule

`default_nettype wire

[sv/particle_physics_step.sv]
// ----------------------------------------------------------------------------
// particle_physics_step: one Euler time step of a particle in Q16.16
// Life, gravity, drag division, position advance, floor bounce and spin,
// all saturated to the signed 32-bit range.
// ----------------------------------------------------------------------------
//
//   channel   handshake              payload
//   -------   --------------------   ------------------------------------------
//   input     in_valid / in_ready    position_*, velocity_*, gravity_accel,
//                                    drag_rate, life_left, rotation,
//                                    spin_rate, is_decal
//   output    out_valid / out_ready  alive, new_position_*, new_velocity_*,
//                                    new_life_left, new_rotation
//   config    cfg_we                 cfg_index, cfg_data (write only)
//
// One transfer per cycle is sustained while out_ready is high; the pipe has three front
// stages, eight divider stages (four quotient bits each) and four back stages.
// The last back stage is the output register.
// Reset clears the valid bits only and loads the register reset values.
// A stalled output freezes the whole pipe; in_ready drops only while a
// result sits in the output register and out_ready is low.
// ----------------------------------------------------------------------------
`default_nettype none

module particle_physics_step #(
    parameter int FRAC_BITS = psp_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,

    input  wire logic                                  cfg_we,
    input  wire logic [psp_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [psp_pkg::CFG_DATA_W-1:0]        cfg_data,

    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic signed [psp_pkg::DATA_W-1:0]     position_x,
    input  wire logic signed [psp_pkg::DATA_W-1:0]     position_y,
    input  wire logic signed [psp_pkg::DATA_W-1:0]     position_z,
    input  wire logic signed [psp_pkg::DATA_W-1:0]     velocity_x,
    input  wire logic signed [psp_pkg::DATA_W-1:0]     velocity_y,
    input  wire logic signed [psp_pkg::DATA_W-1:0]     velocity_z,
    input  wire logic [psp_pkg::GRAV_W-1:0]            gravity_accel,
    input  wire logic [psp_pkg::DRAG_W-1:0]            drag_rate,
    input  wire logic signed [psp_pkg::DATA_W-1:0]     life_left,
    input  wire logic signed [psp_pkg::DATA_W-1:0]     rotation,
    input  wire logic signed [psp_pkg::DATA_W-1:0]     spin_rate,
    input  wire logic                                  is_decal,

    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic                                       alive,
    output logic signed [psp_pkg::DATA_W-1:0]          new_position_x,
    output logic signed [psp_pkg::DATA_W-1:0]          new_position_y,
    output logic signed [psp_pkg::DATA_W-1:0]          new_position_z,
    output logic signed [psp_pkg::DATA_W-1:0]          new_velocity_x,
    output logic signed [psp_pkg::DATA_W-1:0]          new_velocity_y,
    output logic signed [psp_pkg::DATA_W-1:0]          new_velocity_z,
    output logic signed [psp_pkg::DATA_W-1:0]          new_life_left,
    output logic signed [psp_pkg::DATA_W-1:0]          new_rotation
);

    // Configuration registers; an unknown index is dropped
    logic [psp_pkg::DT_W-1:0]            step_time_reg;
    logic signed [psp_pkg::DATA_W-1:0]   floor_height_reg;
    logic [psp_pkg::GAIN_W-1:0]          bounce_gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_time_reg    <= psp_pkg::STEP_TIME_RST;
            floor_height_reg <= psp_pkg::FLOOR_HEIGHT_RST;
            bounce_gain_reg  <= psp_pkg::BOUNCE_GAIN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                psp_pkg::REG_STEP_TIME:
                    step_time_reg <= cfg_data[psp_pkg::DT_W-1:0];
                psp_pkg::REG_FLOOR_HEIGHT:
                    floor_height_reg <= cfg_data;
                psp_pkg::REG_BOUNCE_GAIN:
                    bounce_gain_reg <= cfg_data[psp_pkg::GAIN_W-1:0];
                default:
                    ;
            endcase
        end
    end

    psp_pkg::cfg_t cfg;
    assign cfg.dt      = step_time_reg;
    assign cfg.floor_h = floor_height_reg;
    assign cfg.gain    = bounce_gain_reg;

    // Gather the input transfer into one item
    psp_pkg::item_t item;
    assign item.px    = position_x;
    assign item.py    = position_y;
    assign item.pz    = position_z;
    assign item.vx    = velocity_x;
    assign item.vy    = velocity_y;
    assign item.vz    = velocity_z;
    assign item.life  = life_left;
    assign item.rot   = rotation;
    assign item.spin  = spin_rate;
    assign item.grav  = gravity_accel;
    assign item.drag  = drag_rate;
    assign item.decal = is_decal;

    // Advance every stage unless a finished result is held at the output
    logic adv;
    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    logic                                                fr_vld;
    logic [psp_pkg::LANES-1:0][psp_pkg::NUM_W-1:0]       fr_num;
    psp_pkg::side_t                                      fr_side;

    psp_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_vld  (in_valid),
        .item    (item),
        .cfg     (cfg),
        .out_vld (fr_vld),
        .num     (fr_num),
        .side    (fr_side)
    );

    logic                                                dv_vld;
    logic [psp_pkg::LANES-1:0][psp_pkg::QUO_W-1:0]       dv_quo;
    psp_pkg::side_t                                      dv_side;

    psp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (fr_vld),
        .num      (fr_num),
        .side_in  (fr_side),
        .out_vld  (dv_vld),
        .quo      (dv_quo),
        .side_out (dv_side)
    );

    psp_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_vld  (dv_vld),
        .quo     (dv_quo),
        .side    (dv_side),
        .cfg     (cfg),
        .out_vld (out_valid),
        .alive   (alive),
        .px      (new_position_x),
        .py      (new_position_y),
        .pz      (new_position_z),
        .vx      (new_velocity_x),
        .vy      (new_velocity_y),
        .vz      (new_velocity_z),
        .life    (new_life_left),
        .rot     (new_rotation)
    );

endmodule

`default_nettype wire

[tb/tb_particle_physics_step.sv]
// ----------------------------------------------------------------------------
// tb_particle_physics_step: self-checking bench for the particle step pipeline
// Drives directed and random particles through both valid/ready channels,
// predicts each result in the bench and compares every transfer field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_particle_physics_step;

    localparam int   LATENCY     = 15;
    localparam int   N_RANDOM    = 1800;
    localparam longint CYCLE_CAP = 400000;

    typedef struct {
        logic signed [31:0] px, py, pz, vx, vy, vz, life, rot, spin;
        logic [psp_pkg::GRAV_W-1:0]  grav;
        logic [psp_pkg::DRAG_W-1:0]  drag;
        logic               decal;
    } particle_t;

    typedef struct {
        logic               alive;
        logic signed [31:0] px, py, pz, vx, vy, vz, life, rot;
    } step_out_t;

    // ------------------------------------------------------------------
    // Scoreboard: holds the bench's copy of the registers, computes the
    // expected step for each accepted particle and checks each result.
    // ------------------------------------------------------------------
    class step_scoreboard;
        logic [psp_pkg::DT_W-1:0]    dt;
        logic signed [31:0] floor_h;
        logic [psp_pkg::GAIN_W-1:0]  gain;
        step_out_t          pending[$];
        int                 errors;

        function new();
            dt = psp_pkg::STEP_TIME_RST; floor_h = psp_pkg::FLOOR_HEIGHT_RST;
            gain = psp_pkg::BOUNCE_GAIN_RST;
            errors = 0;
        endfunction

        function void write_reg(logic [psp_pkg::CFG_IDX_W-1:0] idx, logic [31:0] d);
            if (idx == psp_pkg::REG_STEP_TIME) dt = d[psp_pkg::DT_W-1:0];
            else if (idx == psp_pkg::REG_FLOOR_HEIGHT) floor_h = d;
            else if (idx == psp_pkg::REG_BOUNCE_GAIN) gain = d[psp_pkg::GAIN_W-1:0];
        endfunction

        function longint clamp(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        // round(a*b / 2^16), ties away from zero
        function longint scale(longint a, longint b);
            longint m;
            m = (a < 0) ? -a : a;
            m = (m * b + 64'd32768) >>> 16;
            return (a < 0) ? -m : m;
        endfunction

        function longint shrink(longint v, longint den);
            longint m;
            m = (v < 0) ? -v : v;
            m = ((m <<< 16) + (den >>> 1)) / den;
            return (v < 0) ? -m : m;
        endfunction

        function void note_particle(particle_t p);
            step_out_t e;
            longint life, vx, vy, vz, px, py, pz, rot, den, t;
            t = dt;
            life = clamp(longint'(p.life) - t);
            vx = p.vx; vy = p.vy; vz = p.vz;
            px = p.px; py = p.py; pz = p.pz; rot = p.rot;
            e.alive = life > 0;
            if (e.alive) begin
                vy = clamp(vy - scale(longint'(p.grav), t));
                den = 65536 + scale(longint'(p.drag), t);
                vx = clamp(shrink(vx, den));
                vy = clamp(shrink(vy, den));
                vz = clamp(shrink(vz, den));
                px = clamp(px + scale(vx, t));
                py = clamp(py + scale(vy, t));
                pz = clamp(pz + scale(vz, t));
                if (!p.decal && py < longint'(floor_h)) begin
                    py = floor_h;
                    vy = clamp(scale(vy < 0 ? -vy : vy, longint'(gain)));
                end
                rot = clamp(rot + scale(longint'(p.spin), t));
            end
            e.px = px; e.py = py; e.pz = pz; e.vx = vx; e.vy = vy; e.vz = vz;
            e.life = life; e.rot = rot;
            pending.insert(pending.size(), e);
        endfunction

        function void cmp(string name, logic signed [31:0] exp, logic signed [31:0] act);
            if (exp !== act) begin
                $error("%s: expected %0d, got %0d", name, exp, act);
                errors++;
            end
        endfunction

        function void check_result(step_out_t r);
            step_out_t e;
            if (pending.size() == 0) begin
                $error("result with no particle outstanding");
                errors++;
                return;
            end
            e = pending.pop_front();
            cmp("alive", 32'(e.alive), 32'(r.alive));
            cmp("new_position_x", e.px, r.px);
            cmp("new_position_y", e.py, r.py);
            cmp("new_position_z", e.pz, r.pz);
            cmp("new_velocity_x", e.vx, r.vx);
            cmp("new_velocity_y", e.vy, r.vy);
            cmp("new_velocity_z", e.vz, r.vz);
            cmp("new_life_left", e.life, r.life);
            cmp("new_rotation", e.rot, r.rot);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [psp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [psp_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [31:0] position_x = 0, position_y = 0, position_z = 0;
    logic signed [31:0] velocity_x = 0, velocity_y = 0, velocity_z = 0;
    logic [psp_pkg::GRAV_W-1:0] gravity_accel = '0;
    logic [psp_pkg::DRAG_W-1:0] drag_rate = '0;
    logic signed [31:0] life_left = 0, rotation = 0, spin_rate = 0;
    logic is_decal = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic alive;
    logic signed [31:0] new_position_x, new_position_y, new_position_z;
    logic signed [31:0] new_velocity_x, new_velocity_y, new_velocity_z;
    logic signed [31:0] new_life_left, new_rotation;

    step_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    longint cycles = 0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    particle_physics_step u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .position_x(position_x), .position_y(position_y), .position_z(position_z),
        .velocity_x(velocity_x), .velocity_y(velocity_y), .velocity_z(velocity_z),
        .gravity_accel(gravity_accel), .drag_rate(drag_rate), .life_left(life_left),
        .rotation(rotation), .spin_rate(spin_rate), .is_decal(is_decal),
        .out_valid(out_valid), .out_ready(out_ready), .alive(alive),
        .new_position_x(new_position_x), .new_position_y(new_position_y),
        .new_position_z(new_position_z), .new_velocity_x(new_velocity_x),
        .new_velocity_y(new_velocity_y), .new_velocity_z(new_velocity_z),
        .new_life_left(new_life_left), .new_rotation(new_rotation)
    );

    // Watchdog: end the run if the pipe never drains.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Sample each output transfer at the rising edge and check it.
    always @(posedge clk)
    begin
        step_out_t r;
        if (rst_n && out_valid && out_ready) begin
            r.alive = alive;
            r.px = new_position_x; r.py = new_position_y; r.pz = new_position_z;
            r.vx = new_velocity_x; r.vy = new_velocity_y; r.vz = new_velocity_z;
            r.life = new_life_left; r.rot = new_rotation;
            sb.check_result(r);
        end
    end

    // Receiver: stall at random on the falling edge.
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Write one register; the pipe must already be empty.
    task automatic write_reg(logic [psp_pkg::CFG_IDX_W-1:0] idx, logic [31:0] d);
        @(negedge clk);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= d;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, d);
    endtask

    // Present one particle and hold it until the transfer.
    task automatic send_particle(particle_t p);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        position_x <= p.px; position_y <= p.py; position_z <= p.pz;
        velocity_x <= p.vx; velocity_y <= p.vy; velocity_z <= p.vz;
        gravity_accel <= p.grav; drag_rate <= p.drag; life_left <= p.life;
        rotation <= p.rot; spin_rate <= p.spin; is_decal <= p.decal;
        do @(posedge clk); while (!in_ready);
        sb.note_particle(p);
    endtask

    // Drop valid and wait for the pipe to drain before a register write.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    function automatic logic signed [31:0] rnd32();
        case ($urandom_range(5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $signed($urandom_range(0, 2000000)) - 1000000;
            3: return $signed($urandom_range(0, 40000)) - 20000;
            default: return $urandom;
        endcase
    endfunction

    function automatic particle_t rnd_particle();
        particle_t p;
        p.px = rnd32(); p.pz = rnd32(); p.vx = rnd32(); p.vy = rnd32(); p.vz = rnd32();
        p.rot = rnd32(); p.spin = rnd32();
        p.py = ($urandom_range(3) == 0) ? rnd32() : $signed($urandom_range(0, 400000)) - 100000;
        p.grav = ($urandom_range(3) == 0) ? psp_pkg::GRAV_W'($urandom)
                                          : psp_pkg::GRAV_W'($urandom_range(0, 65536000));
        p.drag = ($urandom_range(3) == 0) ? psp_pkg::DRAG_W'($urandom)
                                          : psp_pkg::DRAG_W'($urandom_range(0, 655360));
        // mostly living particles, some near and past end of life
        case ($urandom_range(7))
            0: p.life = rnd32();
            1: p.life = $urandom_range(0, 140000);
            default: p.life = $urandom_range(140000, 32'h7fffffff);
        endcase
        p.decal = 1'($urandom_range(1));
        return p;
    endfunction

    task automatic directed();
        particle_t p;
        p = '{default: 0};
        p.life = 32'sd655360; p.py = 32'sd655360;
        send_particle(p);
        p.px = 32'sh7fffffff; p.vx = 32'sh7fffffff; p.vy = 32'sh80000000;
        p.vz = 32'sh80000000; p.rot = 32'sh7fffffff; p.spin = 32'sh7fffffff;
        p.grav = '1; p.drag = '1;
        send_particle(p);
        p.px = 32'sh80000000; p.pz = 32'sh7fffffff; p.rot = 32'sh80000000;
        p.spin = 32'sh80000000; p.vy = 32'sh7fffffff; p.vx = 32'sh80000000;
        p.vz = 32'sh7fffffff;
        send_particle(p);
        // life runs out exactly, just survives, is already negative and saturates, starts at the maximum
        p = '{default: 0};
        p.vx = 100000; p.py = -200000; p.spin = 5000;
        p.life = 1092; send_particle(p);
        p.life = 1093; send_particle(p);
        p.life = 32'sh80000000; send_particle(p);
        p.life = 32'sh7fffffff; send_particle(p);
        // below the floor: bounce, and a decal that does not bounce
        p.life = 100000; p.vy = -300000; p.grav = psp_pkg::GRAV_W'(642252);
        p.decal = 1'b0; send_particle(p);
        p.decal = 1'b1; send_particle(p);
        p.drag = psp_pkg::DRAG_W'(655360); p.vy = 300000; p.decal = 1'b0; send_particle(p);
        p.py = 32'sh80000000; p.vy = 32'sh80000000; send_particle(p);
    endtask

    task automatic random_phase(int n);
        repeat (n) send_particle(rnd_particle());
        drain();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 17; recv_idle_pct = 72;
        directed();
        drain();

        // step time and gain at one, zero and their maximum; floor at its extremes and zero
        write_reg(psp_pkg::REG_STEP_TIME, 32'd65536);
        write_reg(psp_pkg::REG_FLOOR_HEIGHT, 32'h80000000);
        write_reg(psp_pkg::REG_BOUNCE_GAIN, 32'd65536);
        directed();
        random_phase(300);

        send_idle_pct = 72; recv_idle_pct = 17;
        write_reg(psp_pkg::REG_STEP_TIME, 32'd0);
        write_reg(psp_pkg::REG_FLOOR_HEIGHT, 32'h7fffffff);
        write_reg(psp_pkg::REG_BOUNCE_GAIN, 32'd0);
        random_phase(300);

        write_reg(psp_pkg::REG_STEP_TIME, 32'h1ffff);
        write_reg(psp_pkg::REG_FLOOR_HEIGHT, 32'd0);
        write_reg(psp_pkg::REG_BOUNCE_GAIN, 32'h1ffff);
        random_phase(300);

        send_idle_pct = 0; recv_idle_pct = 0;
        write_reg(psp_pkg::REG_STEP_TIME, 32'(psp_pkg::STEP_TIME_RST));
        write_reg(psp_pkg::REG_FLOOR_HEIGHT, 32'd32768);
        write_reg(psp_pkg::REG_BOUNCE_GAIN, 32'(psp_pkg::BOUNCE_GAIN_RST));
        random_phase(450);

        write_reg(psp_pkg::REG_STEP_TIME, $urandom_range(1, 65536));
        write_reg(psp_pkg::REG_FLOOR_HEIGHT, $urandom);
        write_reg(psp_pkg::REG_BOUNCE_GAIN, $urandom_range(0, 65536));
        random_phase(450);

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire

[particle_physics_step.f]
sv/psp_pkg.sv
sv/psp_front.sv
sv/psp_div.sv
sv/psp_back.sv
sv/particle_physics_step.sv
tb/tb_particle_physics_step.sv
